FILE: rtl/core/tlb_lookup_translate_top_macros.svh
// ----------------------------------------------------------------------------
// tlb_lookup_translate_top_macros
// Assertion macros shared by the translation buffer modules.
// ----------------------------------------------------------------------------
`ifndef TLB_LOOKUP_TRANSLATE_TOP_MACROS_SVH
`define TLB_LOOKUP_TRANSLATE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TLBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TLBT_ASSERT(lbl, prop, msg)
`define TLBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/tlbt_pkg.sv
// ----------------------------------------------------------------------------
// tlbt_pkg
// Types and constants of the translation buffer cell chain.
// ----------------------------------------------------------------------------
package tlbt_pkg;

  localparam int TLB_ENTRIES = 32;
  localparam int IDX_W       = 5;
  localparam int MASK_W      = 12;
  localparam int LO_W        = 26;
  localparam int PN_W        = 42;
  localparam int PFN_W       = 20;
  localparam int IN_DATA_W   = 200;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XLATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_INVALID = 2'd2,
    ST_MOD     = 2'd3
  } status_t;

  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [63:0]       word;
    logic [MASK_W-1:0] mask;
    logic              glob;
    logic [LO_W-1:0]   lo_even;
    logic [LO_W-1:0]   lo_odd;
    logic              store;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
  } tlbt_tok_t;

  function automatic logic [PN_W-1:0] page_num(input logic [63:0] a);
    page_num = {a[63:62], a[39:0]};
  endfunction

endpackage

FILE: rtl/core/tlbt_cell.sv
// ----------------------------------------------------------------------------
// tlbt_cell
// One buffer entry: loads on a matching write, compares passing translates.
// ----------------------------------------------------------------------------
`include "tlb_lookup_translate_top_macros.svh"

module tlbt_cell
  import tlbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [IDX_W-1:0] cell_id,
  input  logic [7:0]       asid,
  input  tlbt_tok_t        tok_i,
  output tlbt_tok_t        tok_o
);

  logic              used_r;
  logic [63:0]       high_r;
  logic [MASK_W-1:0] mask_r;
  logic              glob_r;
  logic [LO_W-1:0]   even_r;
  logic [LO_W-1:0]   odd_r;
  tlbt_tok_t         tok_r;
  tlbt_tok_t         tok_nxt;
  logic              wr_hit;
  logic              match;
  logic [PN_W-1:0]   keep;

  assign wr_hit = en && tok_i.vld && (tok_i.cmd == CMD_WRITE) && (tok_i.idx == cell_id);
  assign keep   = {{(PN_W-MASK_W-13){1'b0}}, mask_r, 13'h1fff};
  assign match  = used_r && (tok_i.cmd == CMD_XLATE) && !tok_i.hit
               && (glob_r || (high_r[7:0] == asid))
               && (((page_num(high_r) ^ page_num(tok_i.word)) & ~keep) == '0);

  always_comb begin
    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = cell_id;
      tok_nxt.mask    = mask_r;
      tok_nxt.lo_even = even_r;
      tok_nxt.lo_odd  = odd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (wr_hit) begin
      used_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      high_r <= tok_i.word;
      mask_r <= tok_i.mask;
      glob_r <= tok_i.glob;
      even_r <= tok_i.lo_even;
      odd_r  <= tok_i.lo_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  `TLBT_ASSERT_NEXT(a_write_marks_used, wr_hit, used_r, "write did not mark entry used")
  `TLBT_ASSERT_NEXT(a_hit_kept, en && tok_i.vld && tok_i.hit,
                    tok_o.hit && (tok_o.hit_idx == $past(tok_i.hit_idx)),
                    "earlier hit lost or replaced")
  `TLBT_ASSERT(a_hit_only_xlate, !(tok_o.vld && tok_o.hit) || (tok_o.cmd == CMD_XLATE),
               "write transfer marked as hit")

endmodule

FILE: rtl/core/tlbt_out.sv
// ----------------------------------------------------------------------------
// tlbt_out
// Result stage: picks the page half, forms status and physical address.
// ----------------------------------------------------------------------------
`include "tlb_lookup_translate_top_macros.svh"

module tlbt_out
  import tlbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  tlbt_tok_t             tok,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [31:0]      m32;
  logic [31:0]      odd_bit;
  logic [LO_W-1:0]  lo;
  status_t          st;
  logic [31:0]      pa;
  logic [IDX_W-1:0] midx;
  logic             vld_r;
  status_t          st_r;
  logic [31:0]      pa_r;
  logic [IDX_W-1:0] idx_r;

  assign m32     = {8'h00, tok.mask, 12'hfff};
  assign odd_bit = m32 + 32'd1;
  assign lo      = ((tok.word[31:0] & odd_bit) != '0) ? tok.lo_odd : tok.lo_even;

  always_comb begin
    st   = ST_OK;
    pa   = '0;
    midx = '0;
    if (tok.cmd == CMD_XLATE) begin
      if (!tok.hit) begin
        st = ST_MISS;
      end else begin
        midx = tok.hit_idx;
        if (!lo[1]) begin
          st = ST_INVALID;
        end else if (tok.store && !lo[2]) begin
          st = ST_MOD;
        end else begin
          pa = {lo[LO_W-1:6], 12'h000} | (tok.word[31:0] & m32);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st;
      pa_r  <= pa;
      idx_r <= midx;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, idx_r, pa_r, st_r};

  `TLBT_ASSERT_NEXT(a_result_follows, en && tok.vld, out_tvalid, "result transfer dropped")
  `TLBT_ASSERT(a_miss_zero, !(out_tvalid && (st_r == ST_MISS)) || ((pa_r == '0) && (idx_r == '0)),
               "miss carries address or index")
  `TLBT_ASSERT(a_fault_no_addr, !(out_tvalid && (st_r != ST_OK)) || (pa_r == '0),
               "faulting result carries address")

endmodule

FILE: rtl/core/tlb_lookup_translate_top.sv
// Each input transfer is registered in every entry cell in turn and then in the result stage.
// Throughput: one transfer per cycle; each item walks the chain of entry cells,
// one cell per cycle, and the whole chain holds while the result is not taken.
// Reset: synchronous, active low; clears all entries to unused and ASID to zero.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
// tlb_lookup_translate_top
// Fully associative translation buffer built as a chain of entry cells.
// ----------------------------------------------------------------------------
module tlb_lookup_translate_top
  import tlbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data,    // current_asid
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,    // command
  // entry_index, entry_hi, page_mask, global_bit, lo_even, lo_odd, virt_addr, is_store
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // status, phys_addr, matched_index
);

  logic [7:0] asid_r;
  logic       en;
  tlbt_tok_t  chain [TLB_ENTRIES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asid_r <= '0;
    end else if (cfg_valid) begin
      asid_r <= cfg_data;
    end
  end

  assign en        = !(out_tvalid && !out_tready);
  assign in_tready = en;

  always_comb begin
    chain[0].vld     = in_tvalid;
    chain[0].cmd     = cmd_t'(in_tuser);
    chain[0].idx     = in_tdata[4:0];
    chain[0].word    = in_tuser ? in_tdata[197:134] : in_tdata[68:5];
    chain[0].mask    = in_tdata[80:69];
    chain[0].glob    = in_tdata[81];
    chain[0].lo_even = in_tdata[107:82];
    chain[0].lo_odd  = in_tdata[133:108];
    chain[0].store   = in_tdata[198];
    chain[0].hit     = 1'b0;
    chain[0].hit_idx = '0;
  end

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    tlbt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .cell_id (IDX_W'(i)),
      .asid    (asid_r),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
  end

  tlbt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .tok        (chain[TLB_ENTRIES]),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Runs entry loads and address translations through the translation buffer
// over the stream ports and changes the ASID between bursts of traffic. A
// shadow copy of the entries predicts every result, and each result is
// compared field by field in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import tlbt_pkg::*;

  typedef struct packed {
    logic              pad;
    logic              store;
    logic [63:0]       va;
    logic [LO_W-1:0]   odd;
    logic [LO_W-1:0]   even;
    logic              glob;
    logic [MASK_W-1:0] mask;
    logic [63:0]       hi;
    logic [IDX_W-1:0]  idx;
  } xlate_item_t;

  typedef struct packed {
    logic             pad;
    logic [IDX_W-1:0] idx;
    logic [31:0]      phys;
    status_t          status;
  } xlate_result_t;

  class tlb_shadow;
    logic [63:0]       ent_hi[TLB_ENTRIES];
    logic [MASK_W-1:0] ent_mask[TLB_ENTRIES];
    logic              ent_glob[TLB_ENTRIES];
    logic [LO_W-1:0]   ent_even[TLB_ENTRIES];
    logic [LO_W-1:0]   ent_odd[TLB_ENTRIES];
    bit                ent_used[TLB_ENTRIES];
    logic [7:0]        asid;
    xlate_result_t     expected_xlates[$];
    int                errors;

    function new();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        ent_hi[i] = '0;
        ent_mask[i] = '0;
        ent_glob[i] = 1'b0;
        ent_even[i] = '0;
        ent_odd[i] = '0;
        ent_used[i] = 1'b0;
      end
      asid = 8'h00;
      errors = 0;
    endfunction

    function logic [PN_W-1:0] page_of(logic [63:0] a, logic [MASK_W-1:0] m);
      logic [PN_W-1:0] keep;
      keep = {17'b0, m, 13'h1fff};
      return {a[63:62], a[39:0]} & ~keep;
    endfunction

    function int outstanding();
      return expected_xlates.size();
    endfunction

    function void note_item(cmd_t cmd, xlate_item_t it);
      xlate_result_t res;
      int hit;
      logic [31:0] m32;
      logic [LO_W-1:0] lo;
      res = '0;
      res.status = ST_OK;
      if (cmd == CMD_WRITE) begin
        ent_hi[it.idx] = it.hi;
        ent_mask[it.idx] = it.mask;
        ent_glob[it.idx] = it.glob;
        ent_even[it.idx] = it.even;
        ent_odd[it.idx] = it.odd;
        ent_used[it.idx] = 1'b1;
      end else begin
        hit = -1;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (hit < 0 && ent_used[i] && (ent_glob[i] || ent_hi[i][7:0] == asid) &&
              page_of(ent_hi[i], ent_mask[i]) == page_of(it.va, ent_mask[i]))
            hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          res.idx = hit[IDX_W-1:0];
          m32 = {8'h00, ent_mask[hit], 12'hfff};
          lo = ((it.va[31:0] & (m32 + 32'd1)) != 32'd0) ? ent_odd[hit] : ent_even[hit];
          if (!lo[1]) begin
            res.status = ST_INVALID;
          end else if (it.store && !lo[2]) begin
            res.status = ST_MOD;
          end else begin
            res.phys = {lo[25:6], 12'h000} | (it.va[31:0] & m32);
          end
        end
      end
      expected_xlates.push_back(res);
    endfunction

    function void check_result(xlate_result_t got);
      xlate_result_t want;
      if (expected_xlates.size() == 0) begin
        $error("result transfer with nothing pending: status %0d phys %h index %0d",
               got.status, got.phys, got.idx);
        errors++;
        return;
      end
      want = expected_xlates.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.phys !== want.phys) begin
        $error("phys_addr: expected %h, got %h", want.phys, got.phys);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $error("matched_index: expected %0d, got %0d", want.idx, got.idx);
        errors++;
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data = 8'h00;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic                  in_tuser = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  tlb_shadow  shadow;
  bit         idle_on = 1'b1;
  logic [7:0] cur_asid = 8'h00;
  int         hold_cycles = 0;
  int         quiet_cycles = 0;

  tlb_lookup_translate_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // check results, stall the result side, and watch for a hang
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      shadow.check_result(xlate_result_t'(out_tdata));
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold_cycles = $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic xlate_item_t noise_item();
    logic [223:0] noise;
    xlate_item_t it;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[IN_DATA_W-1:0];
    it.pad = 1'b0;
    return it;
  endfunction

  task automatic send(input cmd_t cmd, input xlate_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.note_item(cmd, it);
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [63:0] hi,
                            input logic [MASK_W-1:0] mask, input logic glob,
                            input logic [LO_W-1:0] even, input logic [LO_W-1:0] odd);
    xlate_item_t it;
    it = noise_item();
    it.idx = idx;
    it.hi = hi;
    it.mask = mask;
    it.glob = glob;
    it.even = even;
    it.odd = odd;
    send(CMD_WRITE, it);
  endtask

  task automatic xlate(input logic [63:0] va, input logic store);
    xlate_item_t it;
    it = noise_item();
    it.va = va;
    it.store = store;
    send(CMD_XLATE, it);
  endtask

  // wait until every pending result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_asid(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.asid = value;
    cur_asid = value;
  endtask

  task automatic random_item();
    xlate_item_t it;
    int pick;
    int e;
    int k;
    logic [63:0] keep;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 7))
        0: it.mask = 12'h000;
        1: it.mask = 12'h003;
        2: it.mask = 12'h00f;
        3: it.mask = 12'h03f;
        4: it.mask = 12'h0ff;
        5: it.mask = 12'h3ff;
        6: it.mask = 12'hfff;
        default: it.mask = MASK_W'($urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 1) == 1)
        it.hi[7:0] = cur_asid;
      it.glob = ($urandom_range(0, 3) == 0);
      send(CMD_WRITE, it);
    end else begin
      // aim most translations at a loaded page
      if (pick < 85) begin
        e = $urandom_range(0, TLB_ENTRIES - 1);
        while (!shadow.ent_used[e]) e = (e + 1) % TLB_ENTRIES;
        keep = {39'b0, shadow.ent_mask[e], 13'h1fff};
        it.va = (shadow.ent_hi[e] & ~keep) | (it.va & keep);
        if ($urandom_range(0, 1) == 1)
          it.va[61:40] = shadow.ent_hi[e][61:40];
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(13, 39);
          it.va[k] = ~it.va[k];
        end
      end
      send(CMD_XLATE, it);
    end
  endtask

  initial begin
    logic [63:0] hi0;
    logic [7:0]  phase_asid;
    shadow = new();
    hi0 = 64'h0000_00AB_CDE0_0000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_asid(8'h00);

    xlate(64'h0, 1'b0);
    xlate('1, 1'b1);
    load_entry(5'd0, hi0, 12'h000, 1'b0, {20'hFFFFF, 6'b000110}, {20'h12345, 6'b000010});
    xlate(hi0 | 64'hABC, 1'b1);
    xlate(hi0 | 64'h1FFF, 1'b1);
    xlate(hi0 | 64'h1FFF, 1'b0);
    xlate(hi0 | 64'h3FFF_FF00_0000_0000, 1'b0);
    xlate(hi0 | 64'hC000_0000_0000_0000, 1'b0);
    load_entry(5'd1, hi0, 12'h000, 1'b0, 26'h0, '1);
    xlate(hi0, 1'b0);
    load_entry(5'd0, hi0 | 64'hFF, 12'h000, 1'b0, {20'h00001, 6'b000010}, 26'h0);
    xlate(hi0, 1'b0);
    load_entry(5'd31, '1, 12'hFFF, 1'b1, '1, 26'h0);
    xlate('1, 1'b0);
    xlate(~(64'h1 << 24), 1'b1);
    load_entry(5'd7, 64'h4000_0055_5554_A05A, 12'hA5A, 1'b0,
               {20'hABCDE, 6'b000110}, {20'h13579, 6'b000010});
    xlate(64'h4000_0055_5554_A000, 1'b1);
    drain();
    write_asid(8'hFF);
    xlate(hi0, 1'b1);
    xlate(hi0 | 64'h123, 1'b0);
    drain();
    write_asid(8'h5A);
    xlate(64'h4000_0055_5554_A000, 1'b0);
    xlate(64'h4000_0055_555F_FFFF, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 1)
        phase_asid = 8'h00;
      else if (ph == 4)
        phase_asid = 8'hFF;
      else
        phase_asid = 8'($urandom_range(0, 255));
      write_asid(phase_asid);
      idle_on = (ph != 2 && ph != 7);
      for (int n = 0; n < 140; n++)
        random_item();
    end

    drain();
    repeat (40) @(posedge clk);
    if (shadow.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
